// ----- rtl/header_length_checksum_packet_parser_defines.svh -----
// ----------------------------------------------------------------------------
// header_length_checksum_packet_parser_defines
// assertion macros used by the parser rtl
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_CHECKSUM_PACKET_PARSER_DEFINES_SVH
`define HEADER_LENGTH_CHECKSUM_PACKET_PARSER_DEFINES_SVH

// checked on every clock edge outside reset
`define HLCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define HLCP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hlcp_pkg.sv -----
// ----------------------------------------------------------------------------
// hlcp_pkg
// types and constants of the header/length/checksum packet parser
// ----------------------------------------------------------------------------
package hlcp_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [1:0] REG_HEADER_BYTE = 2'd0;
    localparam logic [1:0] REG_MIN_LENGTH  = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0] RST_HEADER_BYTE = 8'd255;
    localparam logic [8:0] RST_MIN_LENGTH  = 9'd6;
    localparam logic [8:0] RST_MAX_LENGTH  = 9'd259;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_GOOD   = 2'd1;
    localparam logic [1:0] ST_BADSUM = 2'd2;

    localparam logic [8:0] SYNC_BYTES = 9'd2;
    localparam logic [8:0] LEN_POS    = 9'd3;
    localparam logic [8:0] CHECK_POS  = 9'd4;
    localparam logic [8:0] LEN_OFFSET = 9'd4;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [8:0] min_packet_length;
        logic [8:0] max_packet_length;
    } t_cfg;

endpackage

// ----- rtl/hlcp_rx_if.sv -----
// ----------------------------------------------------------------------------
// hlcp_rx_if
// received byte channel, one byte per transfer
// ----------------------------------------------------------------------------
interface hlcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/hlcp_res_if.sv -----
// ----------------------------------------------------------------------------
// hlcp_res_if
// parser result channel, one result per received byte
// ----------------------------------------------------------------------------
interface hlcp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_echo;
    logic       kept;
    logic [8:0] byte_position;
    logic [1:0] status;
    logic [8:0] packet_length;

    modport source (
        output valid, output byte_echo, output kept, output byte_position,
        output status, output packet_length, input ready
    );
    modport sink (
        input valid, input byte_echo, input kept, input byte_position,
        input status, input packet_length, output ready
    );
endinterface

// ----- rtl/hlcp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hlcp_cfg_regs
// apb register file: header byte and packet length limits
// ----------------------------------------------------------------------------
module hlcp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hlcp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hlcp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hlcp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output hlcp_pkg::t_cfg                     o_cfg
);

    hlcp_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte       <= hlcp_pkg::RST_HEADER_BYTE;
            r_cfg.min_packet_length <= hlcp_pkg::RST_MIN_LENGTH;
            r_cfg.max_packet_length <= hlcp_pkg::RST_MAX_LENGTH;
        end else if (wr_en) begin
            unique case (reg_idx)
                hlcp_pkg::REG_HEADER_BYTE: r_cfg.header_byte       <= pwdata[7:0];
                hlcp_pkg::REG_MIN_LENGTH:  r_cfg.min_packet_length <= pwdata[8:0];
                hlcp_pkg::REG_MAX_LENGTH:  r_cfg.max_packet_length <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            hlcp_pkg::REG_HEADER_BYTE: prdata[7:0] = r_cfg.header_byte;
            hlcp_pkg::REG_MIN_LENGTH:  prdata[8:0] = r_cfg.min_packet_length;
            hlcp_pkg::REG_MAX_LENGTH:  prdata[8:0] = r_cfg.max_packet_length;
            default:                   prdata      = '0;
        endcase
    end

endmodule

// ----- rtl/header_length_checksum_packet_parser.sv -----
// ----------------------------------------------------------------------------
// header_length_checksum_packet_parser
// sync/id/length framed packet parser with inverted-sum checksum
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and returns exactly one result per
// byte: the byte echoed, whether it belongs to the current packet and at
// which position, and on the checksum byte a good or bad status, with the
// total length when good. A byte is taken every clock cycle unless stalled;
// its result appears on the output in the next cycle, held in a single
// result register, and the input keeps accepting while that register is
// free or being emptied in the same cycle. The header byte and the length
// limits are set over the APB port (0x0 header, 0x4 min length, 0x8 max
// length) and should only be written while no packet is in flight.
// ----------------------------------------------------------------------------
`include "header_length_checksum_packet_parser_defines.svh"

module header_length_checksum_packet_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    hlcp_rx_if.sink                            i_rx,
    hlcp_res_if.source                         o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hlcp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hlcp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hlcp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    hlcp_pkg::t_cfg cfg;

    hlcp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // parser state
    logic [8:0] r_count, n_count;
    logic [8:0] r_exp_len, n_exp_len;
    logic [7:0] r_sum, n_sum;

    // result register
    logic       r_valid;
    logic [7:0] r_echo;
    logic       r_kept, n_kept;
    logic [8:0] r_position, n_position;
    logic [1:0] r_status, n_status;
    logic [8:0] r_plen, n_plen;

    logic       in_fire;
    logic [7:0] c;
    logic [8:0] next_pos;
    logic       len_bad;

    assign i_rx.ready = !r_valid || o_res.ready;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign c          = i_rx.rx_byte;
    assign next_pos   = r_count + 9'd1;
    assign len_bad    = (r_count == hlcp_pkg::CHECK_POS) &&
                        ((r_exp_len < cfg.min_packet_length) ||
                         (r_exp_len > cfg.max_packet_length));

    always_comb begin
        n_count    = r_count;
        n_exp_len  = r_exp_len;
        n_sum      = r_sum;
        n_kept     = 1'b0;
        n_position = '0;
        n_status   = hlcp_pkg::ST_BUSY;
        n_plen     = '0;
        if (r_count < hlcp_pkg::SYNC_BYTES) begin
            if (c == cfg.header_byte) begin
                n_kept     = 1'b1;
                n_position = r_count;
                n_count    = next_pos;
                n_sum      = '0;
            end else begin
                n_count   = '0;
                n_exp_len = '0;
                n_sum     = '0;
            end
        end else if (r_count <= hlcp_pkg::LEN_POS) begin
            n_kept     = 1'b1;
            n_position = r_count;
            n_count    = next_pos;
            n_sum      = r_sum + c;
            if (r_count == hlcp_pkg::LEN_POS) begin
                n_exp_len = {1'b0, c} + hlcp_pkg::LEN_OFFSET;
            end
        end else if (len_bad) begin
            n_count   = '0;
            n_exp_len = '0;
            n_sum     = '0;
        end else begin
            n_kept     = 1'b1;
            n_position = r_count;
            if (next_pos < r_exp_len) begin
                n_count = next_pos;
                n_sum   = r_sum + c;
            end else begin
                // checksum byte closes the packet
                if (~r_sum == c) begin
                    n_status = hlcp_pkg::ST_GOOD;
                    n_plen   = next_pos;
                end else begin
                    n_status = hlcp_pkg::ST_BADSUM;
                end
                n_count   = '0;
                n_exp_len = '0;
                n_sum     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_exp_len <= '0;
            r_sum     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count   <= n_count;
                r_exp_len <= n_exp_len;
                r_sum     <= n_sum;
                r_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_echo     <= c;
            r_kept     <= n_kept;
            r_position <= n_position;
            r_status   <= n_status;
            r_plen     <= n_plen;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.byte_echo     = r_echo;
    assign o_res.kept          = r_kept;
    assign o_res.byte_position = r_position;
    assign o_res.status        = r_status;
    assign o_res.packet_length = r_plen;

    // a packet in its body always has bytes still to come
    `HLCP_ASSERT(a_body_below_total, i_clk, i_rst_n, (r_count > hlcp_pkg::CHECK_POS) |-> (r_count < r_exp_len), "count reached expected length without completing")
    // any completion returns the parser to idle
    `HLCP_ASSERT(a_idle_after_done, i_clk, i_rst_n, (in_fire && (n_status != hlcp_pkg::ST_BUSY)) |=> ((r_count == '0) && (r_sum == '0)), "parser not idle after packet end")
    // a good packet reports a length one past the checksum position
    `HLCP_ASSERT(a_good_length, i_clk, i_rst_n, (r_valid && (r_status == hlcp_pkg::ST_GOOD)) |-> (r_kept && (r_plen == r_position + 9'd1)), "good packet length mismatch")

endmodule
